/* rtl/ctint_pkg.sv */
// Shared types and constants for the cubic trajectory interpolator.
package ctint_pkg;

  localparam int unsigned TimeW  = 24;
  localparam int unsigned PosW   = 32;
  localparam int unsigned StepW  = 16;
  localparam int unsigned FracW  = 32;
  localparam int unsigned CoefW  = 64;
  localparam int unsigned McandW = 64;
  localparam int unsigned ProdW  = McandW + FracW;
  localparam int unsigned CntW   = $clog2(FracW + 1);

  localparam logic [StepW-1:0] StepReset = 16'd655;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_MA,
    ST_LD_MB,
    ST_TK_DIV,
    ST_TK_LIN,
    ST_TK_S2,
    ST_TK_S3,
    ST_TK_QA,
    ST_TK_QB,
    ST_FIN
  } state_e;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

endpackage

/* rtl/cubic_trajectory_interpolator_core.sv */
// Top level of the cubic trajectory interpolator with imposed end velocities.
//
// A load item defines one segment; when the end time is after the start
// time, two bit-serial multiplications then solve the cubic coefficients
// before the next item is accepted, and a load gives no result. A tick item
// returns one sample: the relative time is normalized by a restoring divider
// and the polynomial terms are formed by five passes through one shared
// bit-serial multiplier, after which the sample is written to the output
// register from the finish state and the next item is accepted. A tick with no
// live segment goes straight to the finish state and writes its status 1
// sample there, after which the next item is accepted. One result register
// sits on the output, so the next item is taken while a result waits; a
// finished sample waits in the finish state until that register is free. The
// time step register may be written at any idle moment and resets to 655.
module cubic_trajectory_interpolator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ctint_pkg::StepW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [ctint_pkg::TimeW-1:0]   start_time_i,
  input  logic [ctint_pkg::TimeW-1:0]   end_time_i,
  input  logic signed [ctint_pkg::PosW-1:0] start_position_i,
  input  logic signed [ctint_pkg::PosW-1:0] end_position_i,
  input  logic signed [ctint_pkg::PosW-1:0] start_velocity_i,
  input  logic signed [ctint_pkg::PosW-1:0] end_velocity_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ctint_pkg::PosW-1:0] position_o,
  output logic                          last_sample_o,
  output logic                          status_o
);
  import ctint_pkg::*;

  state_e state_q, state_d;

  logic in_acc, out_free, is_tick;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_tick  = (req_e'(req_type_i) == REQ_TICK);
  assign out_free = !out_valid_o || !out_stall_i;

  // Configuration.
  logic [StepW-1:0] step_q;

  // Segment state.
  logic [TimeW-1:0]  cur_q, seg_start_q, seg_end_q, span_q, tau_q;
  logic              seg_valid_q;
  logic [PosW-1:0]   c0_q, c1_q;
  logic [CoefW-1:0]  ca_q, cb_q;

  // Load scratch values.
  logic [PosW:0]     diff_q;
  logic [PosW+1:0]   t1_q;
  logic [PosW:0]     t2_q;

  // Tick scratch values.
  logic [FracW-1:0]  s_q, s2_q, s3_q;
  logic [CoefW-1:0]  acc_q;
  logic              last_q, nosamp_q;

  // Output register.
  logic              ov_q;
  logic [PosW-1:0]   pos_q;
  logic              lasto_q, stat_q;

  // Serial units.
  logic              mul_start, div_start;
  logic [McandW-1:0] mcand;
  logic [FracW-1:0]  mplier;
  ser_stat_t         mul_stat, div_stat;
  logic [ProdW-1:0]  prod;
  logic [FracW-1:0]  quot;

  // Operands that the first unit of an item needs on its accepting edge come
  // straight from the ports and the segment state, not from the scratch
  // registers that are loaded on that same edge.
  logic [TimeW-1:0]  tau_w, span_w, span_in;
  logic [PosW+1:0]   t1_in, t1_in_mag;

  assign tau_w     = cur_q - seg_start_q;
  assign span_w    = seg_end_q - seg_start_q;
  assign span_in   = end_time_i - start_time_i;
  assign t1_in     = {start_velocity_i[PosW-1], start_velocity_i, 1'b0}
                   + {{2{end_velocity_i[PosW-1]}}, end_velocity_i};
  assign t1_in_mag = t1_in[PosW+1] ? -t1_in : t1_in;

  ctint_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .stat_o   (mul_stat),
    .prod_o   (prod)
  );

  ctint_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (tau_w),
    .den_i   (span_w),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_tick) begin
            state_d = seg_valid_q ? ST_TK_DIV : ST_FIN;
          end else if (end_time_i > start_time_i) begin
            state_d = ST_LD_MA;
          end
        end
      end
      ST_LD_MA:  if (mul_stat.done) state_d = ST_LD_MB;
      ST_LD_MB:  if (mul_stat.done) state_d = ST_IDLE;
      ST_TK_DIV: if (div_stat.done) state_d = ST_TK_LIN;
      ST_TK_LIN: if (mul_stat.done) state_d = ST_TK_S2;
      ST_TK_S2:  if (mul_stat.done) state_d = ST_TK_S3;
      ST_TK_S3:  if (mul_stat.done) state_d = ST_TK_QA;
      ST_TK_QA:  if (mul_stat.done) state_d = ST_TK_QB;
      ST_TK_QB:  if (mul_stat.done) state_d = ST_FIN;
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Unit starts and operands. A unit starts on the edge that enters its state.
  logic [PosW:0]    t2_mag;
  logic [PosW-1:0]  v1_mag;
  logic [CoefW-1:0] ca_mag, cb_mag;

  always_comb begin
    t2_mag    = t2_q[PosW] ? -t2_q : t2_q;
    v1_mag    = c1_q[PosW-1] ? -c1_q : c1_q;
    ca_mag    = ca_q[CoefW-1] ? -ca_q : ca_q;
    cb_mag    = cb_q[CoefW-1] ? -cb_q : cb_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    mcand     = '0;
    mplier    = '0;
    if (state_d != state_q) begin
      unique case (state_d)
        ST_LD_MA: begin
          mul_start = 1'b1;
          mcand     = McandW'(t1_in_mag);
          mplier    = FracW'(span_in);
        end
        ST_LD_MB: begin
          mul_start = 1'b1;
          mcand     = McandW'(t2_mag);
          mplier    = FracW'(span_q);
        end
        ST_TK_DIV: div_start = 1'b1;
        ST_TK_LIN: begin
          mul_start = 1'b1;
          mcand     = McandW'(v1_mag);
          mplier    = FracW'(tau_q);
        end
        ST_TK_S2: begin
          mul_start = 1'b1;
          mcand     = McandW'(quot);
          mplier    = quot;
        end
        ST_TK_S3: begin
          // The square of s is taken from the product, as s2_q is loaded on the edge that starts the cube.
          mul_start = 1'b1;
          mcand     = McandW'(prod[2*FracW-1:FracW]);
          mplier    = s_q;
        end
        ST_TK_QA: begin
          mul_start = 1'b1;
          mcand     = ca_mag;
          mplier    = s2_q;
        end
        ST_TK_QB: begin
          mul_start = 1'b1;
          mcand     = cb_mag;
          mplier    = s3_q;
        end
        default: ;
      endcase
    end
  end

  // Datapath helpers.
  logic [CoefW-1:0] d64, prod64, sprod_a, sprod_b, lin_r, lin_s, q_r, q_s;
  logic [CoefW-1:0] q_fl;
  logic [TimeW:0]   next_t;

  always_comb begin
    d64     = {{(CoefW-PosW-17){diff_q[PosW]}}, diff_q, 16'b0};
    prod64  = prod[CoefW-1:0];
    sprod_a = t1_q[PosW+1] ? -prod64 : prod64;
    sprod_b = t2_q[PosW] ? -prod64 : prod64;
    lin_r   = (prod64 + 64'd32768) >> 16;
    lin_s   = c1_q[PosW-1] ? -lin_r : lin_r;
    q_fl    = prod[ProdW-1:FracW];
    q_r     = (q_fl + 64'd32768) >> 16;
    q_s     = ((state_q == ST_TK_QA) ? ca_q[CoefW-1] : cb_q[CoefW-1]) ? -q_r : q_r;
    next_t  = {1'b0, cur_q} + (TimeW+1)'(step_q);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= StepReset;
      seg_valid_q <= 1'b0;
      cur_q       <= '0;
      seg_start_q <= '0;
      seg_end_q   <= '0;
      c0_q        <= '0;
      c1_q        <= '0;
      ca_q        <= '0;
      cb_q        <= '0;
      ov_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) step_q <= cfg_data_i;
      if (in_acc) begin
        if (!is_tick) begin
          seg_valid_q <= 1'b0;
          if (end_time_i > start_time_i) begin
            c0_q        <= start_position_i;
            c1_q        <= start_velocity_i;
            seg_start_q <= start_time_i;
            seg_end_q   <= end_time_i;
            cur_q       <= start_time_i;
          end
        end else if (seg_valid_q) begin
          if (next_t >= {1'b0, seg_end_q}) begin
            seg_valid_q <= 1'b0;
          end else begin
            cur_q <= next_t[TimeW-1:0];
          end
        end
      end
      if (state_q == ST_LD_MA && mul_stat.done) begin
        ca_q <= (d64 + (d64 << 1)) - sprod_a;
      end
      if (state_q == ST_LD_MB && mul_stat.done) begin
        cb_q        <= sprod_b - (d64 << 1);
        seg_valid_q <= 1'b1;
      end
      if (state_q == ST_FIN && out_free) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      diff_q   <= {end_position_i[PosW-1], end_position_i}
                - {start_position_i[PosW-1], start_position_i};
      t1_q     <= t1_in;
      t2_q     <= {start_velocity_i[PosW-1], start_velocity_i}
                + {end_velocity_i[PosW-1], end_velocity_i};
      nosamp_q <= !seg_valid_q;
      last_q   <= (next_t >= {1'b0, seg_end_q});
      if (is_tick) begin
        tau_q  <= tau_w;
        span_q <= span_w;
      end else begin
        span_q <= span_in;
      end
    end
    if (state_q == ST_TK_DIV && div_stat.done) s_q <= quot;
    if (state_q == ST_TK_LIN && mul_stat.done) begin
      acc_q <= {{(CoefW-PosW){c0_q[PosW-1]}}, c0_q} + lin_s;
    end
    if (state_q == ST_TK_S2 && mul_stat.done) s2_q <= prod[2*FracW-1:FracW];
    if (state_q == ST_TK_S3 && mul_stat.done) s3_q <= prod[2*FracW-1:FracW];
    if ((state_q == ST_TK_QA || state_q == ST_TK_QB) && mul_stat.done) begin
      acc_q <= acc_q + q_s;
    end
    if (state_q == ST_FIN && out_free) begin
      if (nosamp_q) begin
        pos_q   <= '0;
        lasto_q <= 1'b0;
        stat_q  <= 1'b1;
      end else begin
        if ($signed(acc_q) > $signed({{(CoefW-PosW+1){1'b0}}, {(PosW-1){1'b1}}})) begin
          pos_q <= {1'b0, {(PosW-1){1'b1}}};
        end else if ($signed(acc_q) < -$signed({{(CoefW-PosW){1'b0}}, 1'b1,
                                                {(PosW-1){1'b0}}})) begin
          pos_q <= {1'b1, {(PosW-1){1'b0}}};
        end else begin
          pos_q <= acc_q[PosW-1:0];
        end
        lasto_q <= last_q;
        stat_q  <= 1'b0;
      end
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = ov_q;
  assign position_o    = pos_q;
  assign last_sample_o = lasto_q;
  assign status_o      = stat_q;

endmodule

/* rtl/ctint_mul.sv */
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module ctint_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ctint_pkg::McandW-1:0]  mcand_i,
  input  logic [ctint_pkg::FracW-1:0]   mplier_i,
  output ctint_pkg::ser_stat_t          stat_o,
  output logic [ctint_pkg::ProdW-1:0]   prod_o
);
  import ctint_pkg::*;

  logic [ProdW-1:0]  prod_q, prod_d;
  logic [McandW-1:0] mcand_q;
  logic [FracW-1:0]  mplier_q, mplier_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [McandW:0]   sum;

  always_comb begin
    sum      = {1'b0, prod_q[ProdW-1:FracW]} + (mplier_q[0] ? {1'b0, mcand_q} : '0);
    prod_d   = prod_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    if (start_i) begin
      prod_d   = '0;
      mplier_d = mplier_i;
      cnt_d    = CntW'(FracW);
    end else if (cnt_q != '0) begin
      prod_d   = {sum, prod_q[FracW-1:1]};
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q - 1'b1;
      done_d   = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    mplier_q <= mplier_d;
    if (start_i) mcand_q <= mcand_i;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign prod_o      = prod_q;

endmodule

/* rtl/ctint_div.sv */
// Restoring divider giving floor(num * 2^32 / den), one quotient bit per cycle.
module ctint_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ctint_pkg::TimeW-1:0]  num_i,
  input  logic [ctint_pkg::TimeW-1:0]  den_i,
  output ctint_pkg::ser_stat_t         stat_o,
  output logic [ctint_pkg::FracW-1:0]  quot_o
);
  import ctint_pkg::*;

  // The numerator is always below the denominator, so the remainder fits.
  logic [TimeW:0]   rem_q, rem_d, trial;
  logic [TimeW-1:0] den_q;
  logic [FracW-1:0] quot_q, quot_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;

  always_comb begin
    trial  = {rem_q[TimeW-1:0], 1'b0};
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      quot_d = '0;
      cnt_d  = CntW'(FracW);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[FracW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[FracW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) den_q <= den_i;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule
